// ===== src/tlpt_pkg.sv =====
`default_nettype none
package tlpt_pkg;

  localparam int DIR_SIZE   = 1024;
  localparam int TABLE_SIZE = 1024;
  localparam int DIR_IDX_W  = 10;
  localparam int TBL_IDX_W  = 10;
  localparam int OFFSET_W   = 12;
  localparam int FLAGS_W    = 12;
  localparam int ADDR_W     = 32;

  localparam int DIR_IDX_LSB = OFFSET_W + TBL_IDX_W;
  localparam int TBL_IDX_LSB = OFFSET_W;

  // directory entry bit positions
  localparam int DE_PRESENT = 0;
  localparam int DE_WRITE   = 1;
  localparam int DE_USER    = 2;
  localparam int DE_TSHIFT  = 3;

  // page flag bit positions
  localparam int FL_WRITE = 1;
  localparam int FL_USER  = 2;

  localparam logic [ADDR_W-1:0] FRAME_MASK = 32'hFFFF_F000;

  typedef enum logic [1:0] {
    KIND_MAP   = 2'd0,
    KIND_UNMAP = 2'd1,
    KIND_XLATE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_MISS  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_DIR   = 2'd2,
    S_TBL   = 2'd3
  } state_t;

endpackage
`default_nettype wire

// ===== src/tlpt_ifs.sv =====
`default_nettype none
interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] virt_addr;
  logic [31:0] frame_addr;
  logic [11:0] page_flags;

  modport source (output valid, kind, virt_addr, frame_addr, page_flags, input ready);
  modport sink   (input valid, kind, virt_addr, frame_addr, page_flags, output ready);
endinterface

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] phys_result;
  logic [11:0] entry_flags;

  modport source (output valid, status, phys_result, entry_flags, input ready);
  modport sink   (input valid, status, phys_result, entry_flags, output ready);
endinterface
`default_nettype wire

// ===== src/two_level_page_table_manager_core.sv =====
`default_nettype none
// channel   dir  handshake      payload
// in_req    in   valid/ready    kind, virt_addr, frame_addr, page_flags
// out_rsp   out  valid/ready    status, phys_result, entry_flags
//
// map, unmap and a missing translate read the directory, then register the result;
// a translate that finds its table does a directory read, then a table read.
// after reset both memories are swept to zero, with in_req.ready low;
// one transaction is in flight at a time.
// a result waiting in the output register does not block the next accept;
// a finished transaction holds its memory writes until the output is free.
module two_level_page_table_manager_core #(
  parameter int TABLE_POOL_COUNT = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tlpt_req_if.sink    in_req,
  tlpt_rsp_if.source  out_rsp
);

  localparam int TW  = (TABLE_POOL_COUNT > 1) ? $clog2(TABLE_POOL_COUNT) : 1;
  localparam int DW  = tlpt_pkg::DE_TSHIFT + TW;
  localparam int POOL_DEPTH = TABLE_POOL_COUNT * tlpt_pkg::TABLE_SIZE;
  localparam int PAW = $clog2(POOL_DEPTH);

  logic                             dir_we;
  logic [tlpt_pkg::DIR_IDX_W-1:0]   dir_waddr;
  logic [DW-1:0]                    dir_wdata;
  logic                             dir_re;
  logic [tlpt_pkg::DIR_IDX_W-1:0]   dir_raddr;
  logic [DW-1:0]                    dir_rdata;
  logic                             pool_we;
  logic [PAW-1:0]                   pool_waddr;
  logic [tlpt_pkg::ADDR_W-1:0]      pool_wdata;
  logic                             pool_re;
  logic [PAW-1:0]                   pool_raddr;
  logic [tlpt_pkg::ADDR_W-1:0]      pool_rdata;

  tlpt_ctrl #(
    .TABLE_POOL_COUNT(TABLE_POOL_COUNT),
    .TW(TW),
    .DW(DW),
    .PAW(PAW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .req(in_req),
    .rsp(out_rsp),
    .dir_we(dir_we),
    .dir_waddr(dir_waddr),
    .dir_wdata(dir_wdata),
    .dir_re(dir_re),
    .dir_raddr(dir_raddr),
    .dir_rdata(dir_rdata),
    .pool_we(pool_we),
    .pool_waddr(pool_waddr),
    .pool_wdata(pool_wdata),
    .pool_re(pool_re),
    .pool_raddr(pool_raddr),
    .pool_rdata(pool_rdata)
  );

  tlpt_ram #(
    .WIDTH(DW),
    .DEPTH(tlpt_pkg::DIR_SIZE)
  ) u_dir_ram (
    .clk(clk),
    .we(dir_we),
    .waddr(dir_waddr),
    .wdata(dir_wdata),
    .re(dir_re),
    .raddr(dir_raddr),
    .rdata(dir_rdata)
  );

  tlpt_ram #(
    .WIDTH(tlpt_pkg::ADDR_W),
    .DEPTH(POOL_DEPTH)
  ) u_pool_ram (
    .clk(clk),
    .we(pool_we),
    .waddr(pool_waddr),
    .wdata(pool_wdata),
    .re(pool_re),
    .raddr(pool_raddr),
    .rdata(pool_rdata)
  );

endmodule
`default_nettype wire

// ===== src/tlpt_ram.sv =====
`default_nettype none
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/tlpt_ctrl.sv =====
`default_nettype none
module tlpt_ctrl #(
  parameter int TABLE_POOL_COUNT = 64,
  parameter int TW  = (TABLE_POOL_COUNT > 1) ? $clog2(TABLE_POOL_COUNT) : 1,
  parameter int DW  = tlpt_pkg::DE_TSHIFT + TW,
  parameter int PAW = $clog2(TABLE_POOL_COUNT * tlpt_pkg::TABLE_SIZE)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tlpt_req_if.sink                            req,
  tlpt_rsp_if.source                          rsp,
  output logic                                dir_we,
  output logic [tlpt_pkg::DIR_IDX_W-1:0]      dir_waddr,
  output logic [DW-1:0]                       dir_wdata,
  output logic                                dir_re,
  output logic [tlpt_pkg::DIR_IDX_W-1:0]      dir_raddr,
  input  wire logic [DW-1:0]                  dir_rdata,
  output logic                                pool_we,
  output logic [PAW-1:0]                      pool_waddr,
  output logic [tlpt_pkg::ADDR_W-1:0]         pool_wdata,
  output logic                                pool_re,
  output logic [PAW-1:0]                      pool_raddr,
  input  wire logic [tlpt_pkg::ADDR_W-1:0]    pool_rdata
);

  localparam int UW = $clog2(TABLE_POOL_COUNT + 1);
  localparam int POOL_DEPTH = TABLE_POOL_COUNT * tlpt_pkg::TABLE_SIZE;

  tlpt_pkg::state_t state_r, state_nxt;

  logic [PAW-1:0]                      clr_cnt_r, clr_cnt_nxt;
  logic [UW-1:0]                       used_r, used_nxt;
  tlpt_pkg::kind_t                     kind_r;
  logic [tlpt_pkg::ADDR_W-1:0]         va_r;
  logic [tlpt_pkg::ADDR_W-1:0]         pa_r;
  logic [tlpt_pkg::FLAGS_W-1:0]        fl_r;
  logic                                out_valid_r, out_valid_nxt;
  tlpt_pkg::status_t                   out_status_r, out_status_nxt;
  logic [tlpt_pkg::ADDR_W-1:0]         out_phys_r, out_phys_nxt;
  logic [tlpt_pkg::FLAGS_W-1:0]        out_flags_r, out_flags_nxt;

  logic                                accept;
  logic                                out_free;
  logic                                clr_last;
  logic                                de_present;
  logic                                alloc;
  logic                                map_ok;
  logic [TW-1:0]                       tnum;
  logic [DW-1:0]                       de_base;
  logic [DW-1:0]                       de_new;
  logic [tlpt_pkg::DIR_IDX_W-1:0]      didx_r;
  logic [tlpt_pkg::TBL_IDX_W-1:0]      tidx_r;
  logic [PAW-1:0]                      slot;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid_r || rsp.ready;
  assign clr_last = (clr_cnt_r == PAW'(POOL_DEPTH - 1));

  assign didx_r = va_r[tlpt_pkg::DIR_IDX_LSB +: tlpt_pkg::DIR_IDX_W];
  assign tidx_r = va_r[tlpt_pkg::TBL_IDX_LSB +: tlpt_pkg::TBL_IDX_W];

  assign de_present = dir_rdata[tlpt_pkg::DE_PRESENT];
  assign alloc      = !de_present && (used_r < UW'(TABLE_POOL_COUNT));
  assign map_ok     = de_present || alloc;
  assign tnum       = alloc ? used_r[TW-1:0] : dir_rdata[DW-1:tlpt_pkg::DE_TSHIFT];
  assign slot       = PAW'({tnum, tidx_r});

  always_comb begin
    de_base = dir_rdata;
    if (alloc) begin
      de_base = '0;
      de_base[DW-1:tlpt_pkg::DE_TSHIFT] = used_r[TW-1:0];
      de_base[tlpt_pkg::DE_PRESENT] = 1'b1;
      de_base[tlpt_pkg::DE_WRITE] = 1'b1;
    end
    de_new = de_base;
    if (fl_r[tlpt_pkg::FL_USER]) begin
      de_new[tlpt_pkg::DE_USER] = 1'b1;
    end
    if (fl_r[tlpt_pkg::FL_WRITE]) begin
      de_new[tlpt_pkg::DE_WRITE] = 1'b1;
    end
  end

  assign req.ready   = (state_r == tlpt_pkg::S_IDLE);
  assign rsp.valid   = out_valid_r;
  assign rsp.status  = out_status_r;
  assign rsp.phys_result = out_phys_r;
  assign rsp.entry_flags = out_flags_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlpt_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = tlpt_pkg::S_IDLE;
        end
      end
      tlpt_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = tlpt_pkg::S_DIR;
        end
      end
      tlpt_pkg::S_DIR: begin
        if (kind_r == tlpt_pkg::KIND_XLATE && de_present) begin
          state_nxt = tlpt_pkg::S_TBL;
        end else if (out_free) begin
          state_nxt = tlpt_pkg::S_IDLE;
        end
      end
      tlpt_pkg::S_TBL: begin
        if (out_free) begin
          state_nxt = tlpt_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlpt_pkg::S_CLEAR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && !rsp.ready;
    out_status_nxt = out_status_r;
    out_phys_nxt   = out_phys_r;
    out_flags_nxt  = out_flags_r;
    dir_we         = 1'b0;
    dir_waddr      = didx_r;
    dir_wdata      = de_new;
    dir_re         = 1'b0;
    dir_raddr      = req.virt_addr[tlpt_pkg::DIR_IDX_LSB +: tlpt_pkg::DIR_IDX_W];
    pool_we        = 1'b0;
    pool_waddr     = slot;
    pool_wdata     = '0;
    pool_re        = 1'b0;
    pool_raddr     = slot;
    unique case (state_r)
      tlpt_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + PAW'(1);
        pool_we     = 1'b1;
        pool_waddr  = clr_cnt_r;
        pool_wdata  = '0;
        dir_we      = ((clr_cnt_r >> tlpt_pkg::DIR_IDX_W) == '0);
        dir_waddr   = clr_cnt_r[tlpt_pkg::DIR_IDX_W-1:0];
        dir_wdata   = '0;
      end
      tlpt_pkg::S_IDLE: begin
        dir_re = accept;
      end
      tlpt_pkg::S_DIR: begin
        if (kind_r == tlpt_pkg::KIND_XLATE && de_present) begin
          pool_re = 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = tlpt_pkg::ST_MISS;
          out_phys_nxt   = '0;
          out_flags_nxt  = '0;
          case (kind_r)
            tlpt_pkg::KIND_MAP: begin
              if (map_ok) begin
                dir_we         = 1'b1;
                pool_we        = 1'b1;
                pool_wdata     = (pa_r & tlpt_pkg::FRAME_MASK)
                               | {{(tlpt_pkg::ADDR_W - tlpt_pkg::FLAGS_W){1'b0}}, fl_r}
                               | tlpt_pkg::ADDR_W'(1);
                out_status_nxt = tlpt_pkg::ST_OK;
                if (alloc) begin
                  used_nxt = used_r + UW'(1);
                end
              end else begin
                out_status_nxt = tlpt_pkg::ST_NOMEM;
              end
            end
            tlpt_pkg::KIND_UNMAP: begin
              if (de_present) begin
                pool_we        = 1'b1;
                pool_wdata     = '0;
                out_status_nxt = tlpt_pkg::ST_OK;
              end
            end
            default: begin
              out_status_nxt = tlpt_pkg::ST_MISS;
            end
          endcase
        end
      end
      tlpt_pkg::S_TBL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (pool_rdata[0]) begin
            out_status_nxt = tlpt_pkg::ST_OK;
            out_phys_nxt   = {pool_rdata[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFFSET_W],
                              va_r[tlpt_pkg::OFFSET_W-1:0]};
            out_flags_nxt  = pool_rdata[tlpt_pkg::FLAGS_W-1:0];
          end else begin
            out_status_nxt = tlpt_pkg::ST_MISS;
            out_phys_nxt   = '0;
            out_flags_nxt  = '0;
          end
        end
      end
      default: begin
        clr_cnt_nxt = clr_cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpt_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= tlpt_pkg::kind_t'(req.kind);
      va_r   <= req.virt_addr;
      pa_r   <= req.frame_addr;
      fl_r   <= req.page_flags;
    end
    out_status_r <= out_status_nxt;
    out_phys_r   <= out_phys_nxt;
    out_flags_r  <= out_flags_nxt;
  end

endmodule
`default_nettype wire

// ===== sim/tb_two_level_page_table_manager_core.sv =====
`default_nettype none
module tb_two_level_page_table_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpt_pkg::*;

  localparam int POOL_TABLES = 64;
  localparam int TNUM_W      = $clog2(POOL_TABLES);
  localparam int DE_W        = DE_TSHIFT + TNUM_W;
  localparam int RANDOM_REQS = 1700;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] frame_addr;
    logic [FLAGS_W-1:0] page_flags;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [ADDR_W-1:0]  phys_result;
    logic [FLAGS_W-1:0] entry_flags;
  } rsp_t;

  logic clk;
  logic rst_n;

  tlpt_req_if req_if();
  tlpt_rsp_if rsp_if();

  two_level_page_table_manager_core #(
    .TABLE_POOL_COUNT(POOL_TABLES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // shadow paging structures
  logic [DE_W-1:0]   dir_model [DIR_SIZE];
  logic [ADDR_W-1:0] pte_model [POOL_TABLES*TABLE_SIZE];
  int                tables_taken;

  req_t req_backlog[$];
  rsp_t awaited_rsp[$];
  int   mismatch_count;

  int src_gap;
  bit src_burst;
  int snk_stall;
  bit snk_burst;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t walk_page_tables(req_t r);
    rsp_t                 res;
    logic [DIR_IDX_W-1:0] didx;
    logic [TBL_IDX_W-1:0] tidx;
    logic [DE_W-1:0]      de;
    logic                 present;
    int                   tnum;
    int                   slot;
    logic [ADDR_W-1:0]    pte;
    res.status      = ST_MISS;
    res.phys_result = '0;
    res.entry_flags = '0;
    didx    = r.virt_addr[DIR_IDX_LSB +: DIR_IDX_W];
    tidx    = r.virt_addr[TBL_IDX_LSB +: TBL_IDX_W];
    de      = dir_model[didx];
    present = de[DE_PRESENT];
    tnum    = int'(de[DE_TSHIFT +: TNUM_W]);
    case (r.kind)
      KIND_MAP: begin
        if (!present && tables_taken < POOL_TABLES) begin
          tnum = tables_taken;
          tables_taken++;
          de = '0;
          de[DE_TSHIFT +: TNUM_W] = TNUM_W'(tnum);
          de[DE_PRESENT] = 1'b1;
          de[DE_WRITE]   = 1'b1;
          present = 1'b1;
        end
        if (!present) begin
          res.status = ST_NOMEM;
        end else begin
          if (r.page_flags[FL_USER]) de[DE_USER] = 1'b1;
          if (r.page_flags[FL_WRITE]) de[DE_WRITE] = 1'b1;
          dir_model[didx] = de;
          slot = tnum * TABLE_SIZE + int'(tidx);
          pte_model[slot] = (r.frame_addr & FRAME_MASK) | {20'd0, r.page_flags} | 32'd1;
          res.status = ST_OK;
        end
      end
      KIND_UNMAP: begin
        if (present) begin
          slot = tnum * TABLE_SIZE + int'(tidx);
          pte_model[slot] = '0;
          res.status = ST_OK;
        end
      end
      KIND_XLATE: begin
        if (present) begin
          slot = tnum * TABLE_SIZE + int'(tidx);
          pte = pte_model[slot];
          if (pte[0]) begin
            res.status      = ST_OK;
            res.phys_result = (pte & FRAME_MASK) | {20'd0, r.virt_addr[OFFSET_W-1:0]};
            res.entry_flags = pte[FLAGS_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic int pick_idle(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(kind_t k, logic [31:0] va, logic [31:0] pa, logic [11:0] fl);
    req_t r;
    r.kind       = k;
    r.virt_addr  = va;
    r.frame_addr = pa;
    r.page_flags = fl;
    req_backlog.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    req_t cur;
    req_t nxt;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        cur.kind       = kind_t'(req_if.kind);
        cur.virt_addr  = req_if.virt_addr;
        cur.frame_addr = req_if.frame_addr;
        cur.page_flags = req_if.page_flags;
        awaited_rsp.push_back(walk_page_tables(cur));
        src_gap = pick_idle(src_burst);
        if ($urandom_range(0, 99) < 3) src_burst = !src_burst;
      end
      if (!req_if.valid || req_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_if.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          req_if.valid      <= 1'b1;
          req_if.kind       <= nxt.kind;
          req_if.virt_addr  <= nxt.virt_addr;
          req_if.frame_addr <= nxt.frame_addr;
          req_if.page_flags <= nxt.page_flags;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status      = status_t'(rsp_if.status);
        got.phys_result = rsp_if.phys_result;
        got.entry_flags = rsp_if.entry_flags;
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected transaction status %0d phys %h flags %h",
                   $time, got.status, got.phys_result, got.entry_flags);
          mismatch_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.phys_result !== want.phys_result) begin
            $display("%0t: phys_result expected %h actual %h",
                     $time, want.phys_result, got.phys_result);
            mismatch_count++;
          end
          if (got.entry_flags !== want.entry_flags) begin
            $display("%0t: entry_flags expected %h actual %h",
                     $time, want.entry_flags, got.entry_flags);
            mismatch_count++;
          end
        end
      end
      if (snk_stall > 0) begin
        snk_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!snk_burst && $urandom_range(0, 99) < 20) snk_stall = pick_idle(1'b0);
        if ($urandom_range(0, 199) == 0) snk_burst = !snk_burst;
      end
    end
  end

  initial begin
    logic [31:0] known_va[$];
    logic [31:0] va;
    kind_t       k;
    int          r;
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_MAP;
    req_if.virt_addr  = '0;
    req_if.frame_addr = '0;
    req_if.page_flags = '0;
    rsp_if.ready      = 1'b0;
    mismatch_count    = 0;
    tables_taken      = 0;
    src_gap           = 0;
    src_burst         = 1'b0;
    snk_stall         = 0;
    snk_burst         = 1'b0;
    for (int i = 0; i < DIR_SIZE; i++) dir_model[i] = '0;
    for (int i = 0; i < POOL_TABLES*TABLE_SIZE; i++) pte_model[i] = '0;

    // no table yet, reserved kind
    add_req(KIND_XLATE, 32'h0000_0000, 32'h0, 12'h0);
    add_req(KIND_UNMAP, 32'h0000_0000, 32'h0, 12'h0);
    add_req(KIND_RSVD,  32'h1234_5678, 32'h9ABC_DEF0, 12'h5A5);
    // frame zero hit, entry absent in existing table, unmap of absent entry
    add_req(KIND_MAP,   32'h0000_0000, 32'h0000_0000, 12'h000);
    add_req(KIND_XLATE, 32'h0000_0000, 32'h0, 12'h0);
    add_req(KIND_XLATE, 32'h0000_1000, 32'h0, 12'h0);
    add_req(KIND_UNMAP, 32'h0000_1000, 32'h0, 12'h0);
    // all ones extremes
    add_req(KIND_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    add_req(KIND_XLATE, 32'hFFFF_F123, 32'h0, 12'h0);
    add_req(KIND_MAP,   32'hFFC0_0000, 32'h0000_1000, 12'h004);
    add_req(KIND_XLATE, 32'hFFC0_0FFF, 32'h0, 12'h0);
    add_req(KIND_MAP,   32'h0040_0000, 32'h8000_0000, 12'h002);
    add_req(KIND_XLATE, 32'h0040_0ABC, 32'h0, 12'h0);
    add_req(KIND_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h0);
    add_req(KIND_XLATE, 32'hFFFF_FABC, 32'h0, 12'h0);
    add_req(KIND_RSVD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    add_req(KIND_MAP,   32'h1234_5678, 32'hABCD_E123, 12'h5A5);
    add_req(KIND_XLATE, 32'h1234_5FFF, 32'h0, 12'h0);
    add_req(KIND_MAP,   32'h1234_5000, 32'h5555_5000, 12'hA5A);
    add_req(KIND_XLATE, 32'h1234_5000, 32'h0, 12'h0);
    add_req(KIND_UNMAP, 32'h1234_5678, 32'h0, 12'h0);
    add_req(KIND_XLATE, 32'h1234_5678, 32'h0, 12'h0);

    // random mix, mostly reusing mapped pages; fresh directories drain the pool
    for (int i = 0; i < RANDOM_REQS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) k = KIND_MAP;
      else if (r < 60) k = KIND_UNMAP;
      else if (r < 95) k = KIND_XLATE;
      else k = KIND_RSVD;
      if (known_va.size() > 0 && $urandom_range(0, 99) < 70) begin
        va = known_va[$urandom_range(0, known_va.size() - 1)];
        if ($urandom_range(0, 4) == 0) va[TBL_IDX_LSB +: TBL_IDX_W] = TBL_IDX_W'($urandom);
        va[OFFSET_W-1:0] = OFFSET_W'($urandom);
      end else begin
        va = $urandom;
      end
      if (k == KIND_MAP) known_va.push_back(va);
      add_req(k, va, $urandom, 12'($urandom_range(0, 4095)));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || req_if.valid) @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("two_level_page_table_manager_core test passed");
    end else begin
      $display("two_level_page_table_manager_core test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("two_level_page_table_manager_core test failed");
    $finish;
  end

endmodule
`default_nettype wire
